// ===== design/abdnms_pkg.sv =====
// Shared types and constants for the anchor box decode and suppression block.
package abdnms_pkg;

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int CFG_W   = 16;
    localparam int BOX_W   = 4 * COORD_W;
    localparam int ENTRY_W = BOX_W + SCORE_W;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration register indexes
    localparam logic [1:0] REG_SCORE_THR = 2'd0;
    localparam logic [1:0] REG_OVL_THR   = 2'd1;
    localparam logic [1:0] REG_INV_SCALE = 2'd2;

    localparam logic [CFG_W-1:0] SCORE_THR_RST = 16'd32768;
    localparam logic [CFG_W-1:0] OVL_THR_RST   = 16'd26214;
    localparam logic [CFG_W-1:0] INV_SCALE_RST = 16'd4096;

    // Stride codes
    localparam logic [1:0] STRIDE_8  = 2'd0;
    localparam logic [1:0] STRIDE_16 = 2'd1;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_DMUL = 17'h00002,
        S_DSAT = 17'h00004,
        S_WRIT = 17'h00008,
        S_SRD  = 17'h00010,
        S_SCMP = 17'h00020,
        S_SDEC = 17'h00040,
        S_EMIT = 17'h00080,
        S_URD  = 17'h00100,
        S_UWH  = 17'h00200,
        S_UINT = 17'h00400,
        S_UAB  = 17'h00800,
        S_UAA  = 17'h01000,
        S_UUN  = 17'h02000,
        S_ULO  = 17'h04000,
        S_UHI  = 17'h08000,
        S_UCMP = 17'h10000
    } state_t;

endpackage

// ===== design/abdnms_mul.sv =====
// Shared signed multiplier with a registered product.
module abdnms_mul
    import abdnms_pkg::*;
(
    input  logic                     clk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

// ===== design/anchor_box_decode_nms_unit.sv =====
// Anchor decoder with box store and greedy suppression, one shared multiplier.
// Non-final item: dropped, or decoded (4 coords, each via S_DMUL and S_DSAT) and written.
// Final item: then suppression; each selection round compares every stored box, then
// decides; each suppression check runs S_URD to S_UCMP per free box (S_URD, S_UWH if done);
// results wait until taken. in_ready is high only while idle; one transaction at a time.
// rst_n (async, low) restores the register defaults and clears count, flags and done bits.
module anchor_box_decode_nms_unit
    import abdnms_pkg::*;
#(
    parameter int MAX_BOXES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [9:0]                anchor_x,
    input  logic [9:0]                anchor_y,
    input  logic [1:0]                stride_code,
    input  logic [15:0]               dist_left,
    input  logic [15:0]               dist_top,
    input  logic [15:0]               dist_right,
    input  logic [15:0]               dist_bottom,
    input  logic [SCORE_W-1:0]        score,
    input  logic                      frame_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] box_x1,
    output logic signed [COORD_W-1:0] box_y1,
    output logic signed [COORD_W-1:0] box_x2,
    output logic signed [COORD_W-1:0] box_y2,
    output logic [SCORE_W-1:0]        box_score,
    output logic                      box_valid,
    output logic                      store_overflow,
    output logic                      last_box
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] score_thr_reg, ovl_thr_reg, inv_scale_reg;

    logic [CNT_W-1:0]     cnt_reg;
    logic                 ovf_reg;
    logic [MAX_BOXES-1:0] done_reg;
    logic                 found_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [1:0]           k_reg;

    // latched transaction
    logic [9:0]         ax_reg, ay_reg;
    logic [1:0]         code_reg;
    logic [15:0]        dl_reg, dt_reg, dr_reg, db_reg;
    logic [SCORE_W-1:0] sc_reg;
    logic               fe_reg;

    logic [3:0][COORD_W-1:0] coord_reg;
    logic [ENTRY_W-1:0]      mem [MAX_BOXES];
    logic [ENTRY_W-1:0]      rd_reg;
    logic [BOX_W-1:0]        best_box_reg, pend_box_reg;
    logic [SCORE_W-1:0]      best_score_reg, pend_score_reg;

    logic [15:0]        w_reg, h_reg;
    logic signed [16:0] dxa_reg, dya_reg, dxb_reg, dyb_reg;
    logic [32:0]        inter_reg;
    logic signed [34:0] areab_reg;
    logic signed [35:0] uni_reg;
    logic [31:0]        lo_reg;

    logic [BOX_W-1:0]   out_box_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic               out_bv_reg, out_ovf_reg, out_last_reg;

    mul_req_t                 mreq;
    logic signed [PROD_W-1:0] prod;

    abdnms_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    // ---------------- decode datapath ----------------
    logic [17:0] base;
    logic [15:0] dsel;
    logic [20:0] dscaled;
    logic [22:0] edg;

    always_comb
    begin
        base = k_reg[0] ? {ay_reg, 8'd0} : {ax_reg, 8'd0};
        unique case (k_reg)
            2'd0:    dsel = dl_reg;
            2'd1:    dsel = dt_reg;
            2'd2:    dsel = dr_reg;
            default: dsel = db_reg;
        endcase
        if (code_reg == STRIDE_8)
            dscaled = {2'd0, dsel, 3'd0};
        else if (code_reg == STRIDE_16)
            dscaled = {1'd0, dsel, 4'd0};
        else
            dscaled = {dsel, 5'd0};
        edg = k_reg[1] ? ({5'd0, base} + {2'd0, dscaled})
                       : ({5'd0, base} - {2'd0, dscaled});
    end

    logic signed [PROD_W:0]    rnd;
    logic signed [PROD_W-16:0] q;
    logic [COORD_W-1:0]        sat;

    always_comb
    begin
        rnd = (PROD_W+1)'(prod) + (PROD_W+1)'(32768);
        q   = (PROD_W-15)'(rnd >>> 16);
        if (q > (PROD_W-15)'(32767))
            sat = 16'h7fff;
        else if (q < -(PROD_W-15)'(32768))
            sat = 16'h8000;
        else
            sat = q[15:0];
    end

    // ---------------- overlap datapath ----------------
    logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [15:0] mnx2, mxx1, mny2, mxy1;
    logic signed [16:0] wd, hd;
    logic signed [35:0] uni;
    logic [48:0]        lhs;
    logic [49:0]        rhs;
    logic               ovl_hit;

    always_comb
    begin
        ax1 = pend_box_reg[15:0];
        ay1 = pend_box_reg[31:16];
        ax2 = pend_box_reg[47:32];
        ay2 = pend_box_reg[63:48];
        bx1 = rd_reg[15:0];
        by1 = rd_reg[31:16];
        bx2 = rd_reg[47:32];
        by2 = rd_reg[63:48];
        mnx2 = (ax2 < bx2) ? ax2 : bx2;
        mxx1 = (ax1 > bx1) ? ax1 : bx1;
        mny2 = (ay2 < by2) ? ay2 : by2;
        mxy1 = (ay1 > by1) ? ay1 : by1;
        wd = 17'(mnx2) - 17'(mxx1);
        hd = 17'(mny2) - 17'(mxy1);
        uni = 36'(prod[34:0]) + 36'(areab_reg) - $signed({3'd0, inter_reg});
        lhs = {inter_reg, 16'd0};
        rhs = {prod[32:0], 16'd0} + {18'd0, lo_reg};
        ovl_hit = !uni_reg[35] && (uni_reg != '0) && (lhs > rhs[48:0]) && !rhs[49];
    end

    // ---------------- multiplier operand select ----------------
    always_comb
    begin
        mreq.a = '0;
        mreq.b = '0;
        unique case (state_reg)
            S_DMUL:
            begin
                mreq.a = MUL_A_W'($signed(edg));
                mreq.b = {2'd0, inv_scale_reg};
            end
            S_UINT:
            begin
                mreq.a = {9'd0, w_reg};
                mreq.b = {2'd0, h_reg};
            end
            S_UAB:
            begin
                mreq.a = MUL_A_W'(dxb_reg);
                mreq.b = MUL_B_W'(dyb_reg);
            end
            S_UAA:
            begin
                mreq.a = MUL_A_W'(dxa_reg);
                mreq.b = MUL_B_W'(dya_reg);
            end
            S_ULO:
            begin
                mreq.a = {9'd0, uni_reg[15:0]};
                mreq.b = {2'd0, ovl_thr_reg};
            end
            S_UHI:
            begin
                mreq.a = {8'd0, uni_reg[32:16]};
                mreq.b = {2'd0, ovl_thr_reg};
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    logic in_fire, out_fire, kept, full, scan_last, sel_better;
    logic [CNT_W-1:0] cnt_inc;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign kept      = (score >= score_thr_reg);
    assign full      = (cnt_reg == CNT_W'(MAX_BOXES));
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign sel_better = !done_reg[idx_reg]
                        && (!found_reg || (rd_reg[ENTRY_W-1:BOX_W] > best_score_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (kept && !full)
                        state_next = S_DMUL;
                    else if (frame_end)
                        state_next = (cnt_reg == '0) ? S_SDEC : S_SRD;
                end
            end
            S_DMUL: state_next = S_DSAT;
            S_DSAT: state_next = (k_reg == 2'd3) ? S_WRIT : S_DMUL;
            S_WRIT: state_next = fe_reg ? S_SRD : S_IDLE;
            S_SRD:  state_next = S_SCMP;
            S_SCMP: state_next = scan_last ? S_SDEC : S_SRD;
            S_SDEC:
            begin
                if (found_reg && !pend_reg)
                    state_next = S_URD;
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_fire)
                    state_next = out_last_reg ? S_IDLE : S_URD;
            end
            S_URD:  state_next = S_UWH;
            S_UWH:
            begin
                if (!done_reg[idx_reg])
                    state_next = S_UINT;
                else
                    state_next = scan_last ? S_SRD : S_URD;
            end
            S_UINT: state_next = S_UAB;
            S_UAB:  state_next = S_UAA;
            S_UAA:  state_next = S_UUN;
            S_UUN:  state_next = S_ULO;
            S_ULO:  state_next = S_UHI;
            S_UHI:  state_next = S_UCMP;
            S_UCMP: state_next = scan_last ? S_SRD : S_URD;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            score_thr_reg <= SCORE_THR_RST;
            ovl_thr_reg   <= OVL_THR_RST;
            inv_scale_reg <= INV_SCALE_RST;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= '0;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SCORE_THR: score_thr_reg <= cfg_data;
                    REG_OVL_THR:   ovl_thr_reg   <= cfg_data;
                    REG_INV_SCALE: inv_scale_reg <= cfg_data;
                    default:       ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    k_reg     <= '0;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    if (in_fire && kept && full)
                        ovf_reg <= 1'b1;
                end
                S_DSAT: k_reg <= k_reg + 2'd1;
                S_WRIT: cnt_reg <= cnt_inc;
                S_SCMP:
                begin
                    if (sel_better)
                        found_reg <= 1'b1;
                    if (!scan_last)
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                S_SDEC:
                begin
                    idx_reg <= '0;
                    if (found_reg)
                    begin
                        done_reg[best_idx_reg] <= 1'b1;
                        pend_reg               <= 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_fire && out_last_reg)
                    begin
                        cnt_reg  <= '0;
                        ovf_reg  <= 1'b0;
                        done_reg <= '0;
                        pend_reg <= 1'b0;
                    end
                end
                S_UWH:
                begin
                    if (done_reg[idx_reg])
                    begin
                        idx_reg   <= scan_last ? '0 : idx_reg + IDX_W'(1);
                        found_reg <= found_reg && !scan_last;
                    end
                end
                S_UCMP:
                begin
                    if (ovl_hit)
                        done_reg[idx_reg] <= 1'b1;
                    idx_reg   <= scan_last ? '0 : idx_reg + IDX_W'(1);
                    found_reg <= found_reg && !scan_last;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ax_reg   <= anchor_x;
            ay_reg   <= anchor_y;
            code_reg <= stride_code;
            dl_reg   <= dist_left;
            dt_reg   <= dist_top;
            dr_reg   <= dist_right;
            db_reg   <= dist_bottom;
            sc_reg   <= score;
            fe_reg   <= frame_end;
        end
        if (state_reg == S_DSAT)
            coord_reg[k_reg] <= sat;
        if (state_reg == S_WRIT)
            mem[cnt_reg[IDX_W-1:0]] <= {sc_reg, coord_reg};
        if (state_reg == S_SRD || state_reg == S_URD)
            rd_reg <= mem[idx_reg];
        if (state_reg == S_SCMP && sel_better)
        begin
            best_idx_reg   <= idx_reg;
            best_box_reg   <= rd_reg[BOX_W-1:0];
            best_score_reg <= rd_reg[ENTRY_W-1:BOX_W];
        end
        if (state_reg == S_SDEC)
        begin
            out_box_reg   <= pend_reg ? pend_box_reg : '0;
            out_score_reg <= pend_reg ? pend_score_reg : '0;
            out_bv_reg    <= pend_reg;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= !found_reg;
            if (found_reg)
            begin
                pend_box_reg   <= best_box_reg;
                pend_score_reg <= best_score_reg;
            end
        end
        if (state_reg == S_UWH)
        begin
            w_reg   <= wd[16] ? 16'd0 : wd[15:0];
            h_reg   <= hd[16] ? 16'd0 : hd[15:0];
            dxa_reg <= 17'(ax2) - 17'(ax1);
            dya_reg <= 17'(ay2) - 17'(ay1);
            dxb_reg <= 17'(bx2) - 17'(bx1);
            dyb_reg <= 17'(by2) - 17'(by1);
        end
        if (state_reg == S_UAB)
            inter_reg <= prod[32:0];
        if (state_reg == S_UAA)
            areab_reg <= prod[34:0];
        if (state_reg == S_UUN)
            uni_reg <= uni;
        if (state_reg == S_UHI)
            lo_reg <= prod[31:0];
    end

    assign box_x1         = out_box_reg[15:0];
    assign box_y1         = out_box_reg[31:16];
    assign box_x2         = out_box_reg[47:32];
    assign box_y2         = out_box_reg[63:48];
    assign box_score      = out_score_reg;
    assign box_valid      = out_bv_reg;
    assign store_overflow = out_ovf_reg;
    assign last_box       = out_last_reg;

endmodule

// ===== design/abdnms_check.sv =====
// Port-level checker for the anchor decode and suppression block, with its bind.
module abdnms_check
    import abdnms_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [COORD_W-1:0] box_x1,
    input logic [SCORE_W-1:0]        box_score,
    input logic                      box_valid,
    input logic                      last_box
);

    // one transaction in flight: never taking input while a result is offered
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid both high");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(box_x1) && $stable(box_score))
        else $error("stalled result changed");

    // empty-frame result is the only one of its frame
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !box_valid |-> last_box && box_score == '0)
        else $error("empty result not last or nonzero");

    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_box |=> in_ready && !out_valid)
        else $error("block not idle after frame end");

endmodule

bind anchor_box_decode_nms_unit abdnms_check u_abdnms_check (.*);

// ===== tb/sv/anchor_box_decode_nms_unit_tb.sv =====
// Testbench for the anchor box decoder with greedy suppression: random traffic, scoreboard.
module anchor_box_decode_nms_unit_tb
    import abdnms_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [9:0]  ax;
        bit [9:0]  ay;
        bit [1:0]  stride;
        bit [15:0] dl;
        bit [15:0] dt;
        bit [15:0] dr;
        bit [15:0] db;
        bit [15:0] sc;
        bit        fe;
    } anchor_t;

    typedef struct packed {
        bit [15:0] x1;
        bit [15:0] y1;
        bit [15:0] x2;
        bit [15:0] y2;
        bit [15:0] sc;
        bit        valid;
        bit        ovf;
        bit        last;
    } det_t;

    class nms_scoreboard;
        bit [15:0] score_thr;
        bit [15:0] ovl_thr;
        bit [15:0] inv_scale;
        bit [63:0] boxes[64];
        bit [15:0] scores[64];
        bit        taken[64];
        int        count;
        bit        ovf;
        det_t      pending_dets[$];
        int        mismatches;
        int        checked;
        int        frames;
        int        kept_boxes;
        int        overflow_frames;

        function void reset_state();
            score_thr = SCORE_THR_RST;
            ovl_thr   = OVL_THR_RST;
            inv_scale = INV_SCALE_RST;
            count = 0;
            ovf = 0;
            foreach (taken[i]) taken[i] = 0;
        endfunction

        function void write_reg(bit [1:0] idx, bit [15:0] v);
            if (idx == REG_SCORE_THR) score_thr = v;
            else if (idx == REG_OVL_THR) ovl_thr = v;
            else if (idx == REG_INV_SCALE) inv_scale = v;
        endfunction

        function bit [15:0] to_frame(longint edge_q8);
            longint p;
            longint q;
            p = edge_q8 * longint'(inv_scale) + 32768;
            q = p >>> 16;   // floor division
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return q[15:0];
        endfunction

        function longint coord(bit [63:0] b, int k);
            bit [15:0] v;
            v = b[16*k +: 16];
            return longint'($signed(v));
        endfunction

        function bit too_close(bit [63:0] a, bit [63:0] b);
            longint w;
            longint h;
            longint inter;
            longint uni;
            w = ((coord(a, 2) < coord(b, 2)) ? coord(a, 2) : coord(b, 2))
              - ((coord(a, 0) > coord(b, 0)) ? coord(a, 0) : coord(b, 0));
            h = ((coord(a, 3) < coord(b, 3)) ? coord(a, 3) : coord(b, 3))
              - ((coord(a, 1) > coord(b, 1)) ? coord(a, 1) : coord(b, 1));
            if (w < 0) w = 0;
            if (h < 0) h = 0;
            inter = w * h;
            uni = (coord(a, 2) - coord(a, 0)) * (coord(a, 3) - coord(a, 1))
                + (coord(b, 2) - coord(b, 0)) * (coord(b, 3) - coord(b, 1)) - inter;
            if (uni <= 0) return 0;
            return inter * 65536 > longint'(ovl_thr) * uni;
        endfunction

        function void note_anchor(anchor_t a);
            longint stride;
            int best;
            int n;
            det_t d;
            stride = (a.stride == STRIDE_8) ? 8 : (a.stride == STRIDE_16) ? 16 : 32;
            if (a.sc >= score_thr) begin
                if (count >= 64) ovf = 1;
                else begin
                    boxes[count] = {to_frame(longint'(a.ay) * 256 + longint'(a.db) * stride),
                                    to_frame(longint'(a.ax) * 256 + longint'(a.dr) * stride),
                                    to_frame(longint'(a.ay) * 256 - longint'(a.dt) * stride),
                                    to_frame(longint'(a.ax) * 256 - longint'(a.dl) * stride)};
                    scores[count] = a.sc;
                    taken[count] = 0;
                    count++;
                end
            end
            if (!a.fe) return;
            frames++;
            if (ovf) overflow_frames++;
            n = 0;
            forever begin
                best = -1;
                for (int i = 0; i < count; i++)
                    if (!taken[i] && (best < 0 || scores[i] > scores[best])) best = i;
                if (best < 0) break;
                taken[best] = 1;
                d = '{boxes[best][15:0], boxes[best][31:16], boxes[best][47:32],
                      boxes[best][63:48], scores[best], 1'b1, ovf, 1'b0};
                pending_dets = {pending_dets, d};
                n++;
                kept_boxes++;
                for (int i = 0; i < count; i++)
                    if (!taken[i] && too_close(boxes[best], boxes[i])) taken[i] = 1;
            end
            if (n == 0) begin
                d = '{0, 0, 0, 0, 0, 1'b0, ovf, 1'b0};
                pending_dets = {pending_dets, d};
            end
            pending_dets[pending_dets.size() - 1].last = 1;
            count = 0;
            ovf = 0;
            foreach (taken[i]) taken[i] = 0;
        endfunction

        function void check_det(det_t got);
            det_t want;
            checked++;
            if (pending_dets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result x1=%0d y1=%0d x2=%0d y2=%0d sc=%0d",
                             $signed(got.x1), $signed(got.y1), $signed(got.x2),
                             $signed(got.y2), got.sc);
                return;
            end
            want = pending_dets.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d exp (%0d %0d %0d %0d sc %0d v%0b o%0b l%0b)",
                              " got (%0d %0d %0d %0d sc %0d v%0b o%0b l%0b)"}, checked,
                             $signed(want.x1), $signed(want.y1), $signed(want.x2),
                             $signed(want.y2), want.sc, want.valid, want.ovf, want.last,
                             $signed(got.x1), $signed(got.y1), $signed(got.x2),
                             $signed(got.y2), got.sc, got.valid, got.ovf, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [9:0] anchor_x;
    logic [9:0] anchor_y;
    logic [1:0] stride_code;
    logic [15:0] dist_left;
    logic [15:0] dist_top;
    logic [15:0] dist_right;
    logic [15:0] dist_bottom;
    logic [SCORE_W-1:0] score;
    logic frame_end;
    logic out_valid;
    logic out_ready;
    logic signed [COORD_W-1:0] box_x1;
    logic signed [COORD_W-1:0] box_y1;
    logic signed [COORD_W-1:0] box_x2;
    logic signed [COORD_W-1:0] box_y2;
    logic [SCORE_W-1:0] box_score;
    logic box_valid;
    logic store_overflow;
    logic last_box;

    nms_scoreboard detections = new();
    int items_sent;
    int burst_left;
    int stall_mode;
    int stall_cnt;

    anchor_box_decode_nms_unit dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: stall pattern switches between always-ready, periodic and random.
    always @(posedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= (stall_cnt % 5) < 2;
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            detections.check_det('{box_x1, box_y1, box_x2, box_y2, box_score,
                                   box_valid, store_overflow, last_box});
    end

    // Leaves cfg_we high; the caller drops it after the last write.
    task automatic write_cfg(bit [1:0] idx, bit [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        detections.write_reg(idx, v);
    endtask

    task automatic set_thresholds(bit [15:0] st, bit [15:0] ot, bit [15:0] is);
        write_cfg(REG_SCORE_THR, st);
        write_cfg(REG_OVL_THR, ot);
        write_cfg(REG_INV_SCALE, is);
        cfg_we <= 1'b0;
    endtask

    task automatic send_anchor(anchor_t a);
        in_valid <= 1'b1;
        anchor_x <= a.ax;
        anchor_y <= a.ay;
        stride_code <= a.stride;
        dist_left <= a.dl;
        dist_top <= a.dt;
        dist_right <= a.dr;
        dist_bottom <= a.db;
        score <= a.sc;
        frame_end <= a.fe;
        do @(posedge clk); while (!in_ready);
        detections.note_anchor(a);
        items_sent++;
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (detections.pending_dets.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic anchor_t rand_anchor(bit fe);
        anchor_t a;
        a.ax = 10'($urandom);
        a.ay = 10'($urandom);
        a.stride = 2'($urandom);
        a.dl = 16'($urandom);
        a.dt = 16'($urandom);
        a.dr = 16'($urandom);
        a.db = 16'($urandom);
        a.sc = 16'($urandom);
        a.fe = fe;
        return a;
    endfunction

    // Boxes around a shared center with jittered edges, so suppression has work to do.
    function automatic anchor_t near_anchor(int cx, int cy, int sz, bit fe);
        anchor_t a;
        a = rand_anchor(fe);
        a.ax = 10'(cx + $urandom_range(0, 7));
        a.ay = 10'(cy + $urandom_range(0, 7));
        a.stride = 2'($urandom_range(0, 3));
        a.dl = 16'(sz + $urandom_range(0, 300));
        a.dt = 16'(sz + $urandom_range(0, 300));
        a.dr = 16'(sz + $urandom_range(0, 300));
        a.db = 16'(sz + $urandom_range(0, 300));
        return a;
    endfunction

    task automatic random_frame(int len);
        int cx;
        int cy;
        int sz;
        cx = $urandom_range(0, 1000);
        cy = $urandom_range(0, 1000);
        sz = $urandom_range(16, 1200);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_anchor(rand_anchor(i == len - 1));
            end else begin
                if ($urandom_range(0, 5) == 0) begin
                    cx = $urandom_range(0, 1000);
                    cy = $urandom_range(0, 1000);
                end
                send_anchor(near_anchor(cx, cy, sz, i == len - 1));
            end
        end
        drain();
    endtask

    initial
    begin
        anchor_t a;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        anchor_x <= '0;
        anchor_y <= '0;
        stride_code <= '0;
        dist_left <= '0;
        dist_top <= '0;
        dist_right <= '0;
        dist_bottom <= '0;
        score <= '0;
        frame_end <= 1'b0;
        out_ready <= 1'b0;
        stall_mode = 0;
        stall_cnt = 0;
        detections.reset_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, field extremes, every stride code, a frame end on its own
        a = '{0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0};
        send_anchor(a);
        a = '{10'h3FF, 10'h3FF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 0};
        send_anchor(a);
        a = '{320, 320, 2, 256, 256, 256, 256, 16'h9000, 0};
        send_anchor(a);
        a = '{322, 321, 3, 250, 260, 256, 256, 16'h9000, 0};   // tie with the one before
        send_anchor(a);
        a = '{100, 100, 0, 0, 0, 0, 0, 16'hA000, 0};           // zero area box
        send_anchor(a);
        a = '{100, 100, 0, 0, 0, 0, 0, 16'hA000, 0};
        send_anchor(a);
        a = '{500, 500, 1, 100, 100, 100, 100, 16'h7FFF, 1};   // below threshold
        send_anchor(a);
        drain();
        // empty frame
        a = '{5, 5, 0, 10, 10, 10, 10, 16'h0001, 1};
        send_anchor(a);
        drain();

        // Extreme settings: everything kept, nothing overlaps "too much" at max
        set_thresholds(16'd0, 16'hFFFF, 16'hFFFF);
        a = '{10'h3FF, 0, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 0};
        send_anchor(a);
        a = '{0, 10'h3FF, 2, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 0};
        send_anchor(a);
        a = '{512, 512, 0, 40, 40, 40, 40, 16'd7, 1};
        send_anchor(a);
        drain();
        set_thresholds(16'hFFFF, 16'd0, 16'd0);
        a = '{300, 300, 1, 500, 500, 500, 500, 16'hFFFF, 0};
        send_anchor(a);
        a = '{600, 300, 1, 50, 50, 50, 50, 16'hFFFE, 1};
        send_anchor(a);
        drain();

        // Overflow: more kept anchors than the store holds
        set_thresholds(16'd0, 16'd30000, 16'd3072);
        for (int i = 0; i < 70; i++) send_anchor(rand_anchor(i == 69));
        drain();

        // Random frames under a few settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_thresholds(SCORE_THR_RST, OVL_THR_RST, INV_SCALE_RST);
                1: set_thresholds(16'd1000, 16'd13000, 16'd6144);
                2: set_thresholds(16'd40000, 16'd52000, 16'd2048);
                3: set_thresholds(16'd0, 16'd0, 16'd4096);
                4: set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            while (items_sent < 60 + 45 * (ph + 1))
                random_frame($urandom_range(0, 9) == 0 ? $urandom_range(20, 40)
                                                       : $urandom_range(1, 8));
        end
        set_thresholds(16'd100, 16'd20000, 16'd5000);
        for (int i = 0; i < 66; i++) send_anchor(near_anchor(200, 200, 400, i == 65));
        drain();

        $display("Sent %0d anchors in %0d frames; %0d results checked, %0d boxes kept.",
                 items_sent, detections.frames, detections.checked, detections.kept_boxes);
        $display("Frames with store overflow: %0d; mismatches: %0d.",
                 detections.overflow_frames, detections.mismatches);
        if (detections.mismatches == 0 && detections.pending_dets.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
design/abdnms_pkg.sv
design/abdnms_mul.sv
design/anchor_box_decode_nms_unit.sv
design/abdnms_check.sv
tb/sv/anchor_box_decode_nms_unit_tb.sv
